// File: src/phea_pkg.sv
// Shared types, constants and register codes of the per-host rate anomaly block.
`timescale 1ns / 1ps
package phea_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF   = 256;
  localparam int unsigned MAX_DECAY_STEPS_DEF = 1024;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 64;

  localparam logic [1:0] REG_SUBNET = 2'd0;
  localparam logic [1:0] REG_MASK   = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;
  localparam logic [1:0] REG_ALPHA  = 2'd3;

  localparam logic [31:0] SUBNET_RST = 32'h0000_0000;
  localparam logic [31:0] MASK_RST   = 32'hFFFF_FFFF;
  localparam logic [47:0] THRESH_RST = 48'd6553600;
  localparam logic [16:0] ALPHA_RST  = 17'd6554;
  localparam logic [16:0] ALPHA_ONE  = 17'd65536;

  localparam int unsigned ROUND_MS   = 500;
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned SEC_W      = 39;

  localparam logic [2:0] OUT_IGNORED = 3'd0;
  localparam logic [2:0] OUT_NEW     = 3'd1;
  localparam logic [2:0] OUT_SAME    = 3'd2;
  localparam logic [2:0] OUT_NEXT    = 3'd3;
  localparam logic [2:0] OUT_ANOMALY = 3'd4;
  localparam logic [2:0] OUT_GAP     = 3'd5;
  localparam logic [2:0] OUT_FULL    = 3'd6;

  typedef struct packed {
    logic [31:0] subnet;
    logic [31:0] mask;
    logic [47:0] thresh;
    logic [16:0] alpha;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        dir;
    logic [31:0] host;
    logic [38:0] bin;
    logic [31:0] count;
    logic [31:0] rate;
    logic [47:0] ema;
    logic [47:0] open_ms;
  } entry_t;

endpackage

// File: src/phea_if.sv
// Handshake interfaces for flow items and result items.
`timescale 1ns / 1ps
interface phea_flow_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [31:0] packet_count;
  logic [47:0] start_ms;
  modport source (output valid, src_addr, dst_addr, packet_count, start_ms, input ready);
  modport sink (input valid, src_addr, dst_addr, packet_count, start_ms, output ready);
endinterface

interface phea_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic        direction;
  logic [31:0] host_addr;
  logic [38:0] bin_second;
  logic [47:0] bin_start_ms;
  logic [31:0] packet_rate;
  logic [47:0] ema_rate;
  modport source (output valid, outcome, direction, host_addr, bin_second, bin_start_ms,
                  packet_rate, ema_rate, input ready);
  modport sink (input valid, outcome, direction, host_addr, bin_second, bin_start_ms,
                packet_rate, ema_rate, output ready);
endinterface

// File: src/phea_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module phea_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: src/phea_cfg.sv
// APB configuration registers of the per-host rate anomaly block.
`timescale 1ns / 1ps
module phea_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [phea_pkg::CFG_AW-1:0]  paddr,
  input  logic [phea_pkg::CFG_DW-1:0]  pwdata,
  output logic [phea_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output phea_pkg::cfg_t               cfg_o
);
  import phea_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[4:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_SUBNET: cfg_d.subnet = pwdata[31:0];
        REG_MASK:   cfg_d.mask   = pwdata[31:0];
        REG_THRESH: cfg_d.thresh = pwdata[47:0];
        REG_ALPHA:  cfg_d.alpha  = pwdata[16:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SUBNET: prdata = {32'd0, cfg_q.subnet};
      REG_MASK:   prdata = {32'd0, cfg_q.mask};
      REG_THRESH: prdata = {16'd0, cfg_q.thresh};
      REG_ALPHA:  prdata = {47'd0, cfg_q.alpha};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.subnet <= SUBNET_RST;
      cfg_q.mask   <= MASK_RST;
      cfg_q.thresh <= THRESH_RST;
      cfg_q.alpha  <= ALPHA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule

// File: src/phea_sec_div.sv
// Rounded millisecond to second conversion by reciprocal multiplication.
`timescale 1ns / 1ps
module phea_sec_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] ms_i,
  output logic        busy_o,
  output logic [38:0] sec_o
);
  import phea_pkg::*;

  // The rounded time is shifted right by three and divided by 125 in two halves.
  localparam logic [22:0] DIV_LO = 23'(MS_PER_SEC / 8);
  localparam logic [30:0] RECIP  = 31'd1099511628;
  localparam int unsigned RSH    = 37;

  logic [48:0] num_q;
  logic [15:0] qh_q;
  logic [29:0] x_q;
  logic [22:0] ql_q;
  logic [1:0]  cnt_q;
  logic        busy_q;
  logic [22:0] hi;
  logic [22:0] lo;
  logic [29:0] mul_x;
  logic [60:0] prod;
  logic [23:0] q;
  logic [22:0] qh_m;
  logic [22:0] rh;

  assign hi     = num_q[48:26];
  assign lo     = num_q[25:3];
  assign mul_x  = (cnt_q == 2'd3) ? {7'd0, hi} : x_q;
  assign prod   = mul_x * RECIP;
  assign q      = prod[RSH+23:RSH];
  assign qh_m   = {7'd0, qh_q} * DIV_LO;
  assign rh     = hi - qh_m;
  assign busy_o = busy_q;
  assign sec_o  = {qh_q, ql_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd3;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == 2'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= 49'(ms_i) + 49'(ROUND_MS);
    end else if (busy_q) begin
      case (cnt_q)
        2'd3: qh_q <= q[15:0];
        2'd2: x_q  <= {rh[6:0], lo};
        2'd1: ql_q <= q[22:0];
        default: begin
        end
      endcase
    end
  end
endmodule

// File: src/per_host_rate_ema_anomaly.sv
// Top level: per-host packet-rate EWMA anomaly detector over a host table in RAM.
//
//  channel   direction  handshake        carries
//  flow_i    in         valid/ready      src_addr dst_addr packet_count start_ms
//  res_o     out        valid/ready      outcome direction host_addr bin_second
//                                        bin_start_ms packet_rate ema_rate
//  apb       in/out     psel/penable     local_subnet subnet_mask rate_threshold alpha
//
// After reset a clearing pass writes every table entry before the first item is
// taken. An item passes through the seconds conversion, the serial table search
// through the single read port, the EWMA update and, for a gap, up to
// MAX_DECAY_STEPS decay steps. One item is in work at a time; a waiting result
// does not block the next item from being accepted.
`timescale 1ns / 1ps
module per_host_rate_ema_anomaly #(
  parameter int unsigned TABLE_ENTRIES   = phea_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_DECAY_STEPS = phea_pkg::MAX_DECAY_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  phea_flow_if.sink                   flow_i,
  phea_res_if.source                  res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [phea_pkg::CFG_AW-1:0] paddr,
  input  logic [phea_pkg::CFG_DW-1:0] pwdata,
  output logic [phea_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import phea_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned SW = $clog2(MAX_DECAY_STEPS + 1);
  localparam int unsigned EW = $bits(entry_t);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_CASE   = 4'd4;
  localparam logic [3:0] S_NEWMUL = 4'd5;
  localparam logic [3:0] S_NEW    = 4'd6;
  localparam logic [3:0] S_D0     = 4'd7;
  localparam logic [3:0] S_D1     = 4'd8;
  localparam logic [3:0] S_D2     = 4'd9;
  localparam logic [3:0] S_AR     = 4'd10;
  localparam logic [3:0] S_WR     = 4'd11;

  cfg_t cfg;

  logic [3:0]    state_q, state_d;
  logic [AW:0]   iss_q, iss_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] chk_q, chk_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [AW-1:0] free_q, free_d;
  logic          free_ok_q, free_ok_d;
  logic          first_q, first_d;
  logic          nextbin_q, nextbin_d;
  logic [SW-1:0] steps_q, steps_d;
  logic          wen_q, wen_d;
  logic [2:0]    out_q, out_d;
  logic          rv_q, rv_d;

  logic [31:0] host_q, host_d;
  logic        dir_q, dir_d;
  logic [31:0] pkts_q, pkts_d;
  logic [47:0] ms_q, ms_d;
  entry_t      ent_q, ent_d;
  logic [47:0] ew_q, ew_d;
  logic [40:0] lo_q, lo_d;
  logic [48:0] prod_q, prod_d;

  logic [2:0]  res_outcome_q, res_outcome_d;
  logic        res_dir_q, res_dir_d;
  logic [31:0] res_host_q, res_host_d;
  logic [38:0] res_bin_q, res_bin_d;
  logic [47:0] res_open_q, res_open_d;
  logic [31:0] res_rate_q, res_rate_d;
  logic [47:0] res_ema_q, res_ema_d;

  logic          div_start;
  logic          div_busy;
  logic [38:0]   sec;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  entry_t        rd;

  logic [16:0] aeff, keep;
  logic [16:0] mul_a;
  logic [31:0] mul_b;
  logic [72:0] dsum;
  logic [47:0] dec;
  logic [48:0] esum;
  logic [47:0] esat;
  logic [47:0] rq;
  logic [39:0] diff;
  logic [32:0] csum;
  logic        iss_done;
  logic        can_load;
  logic        src_local, dst_local;

  phea_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  phea_sec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .ms_i    (flow_i.start_ms),
    .busy_o  (div_busy),
    .sec_o   (sec)
  );

  phea_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd        = entry_t'(ram_rdata);
  assign aeff      = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign keep      = ALPHA_ONE - aeff;
  assign prod_d    = mul_a * mul_b;
  assign dsum      = {prod_q, 24'd0} + 73'(lo_q) + 73'd32768;
  assign dec       = dsum[63:16];
  assign esum      = prod_q + {1'b0, ew_q};
  assign esat      = esum[48] ? 48'hFFFF_FFFF_FFFF : esum[47:0];
  assign rq        = {ent_q.count, 16'd0};
  assign diff      = {1'b0, sec} - {1'b0, ent_q.bin} - 40'd1;
  assign csum      = {1'b0, ent_q.count} + {1'b0, pkts_q};
  assign iss_done  = iss_q == (AW + 1)'(TABLE_ENTRIES);
  assign can_load  = !rv_q || res_o.ready;
  assign src_local = (flow_i.src_addr & cfg.mask) == cfg.subnet;
  assign dst_local = (flow_i.dst_addr & cfg.mask) == cfg.subnet;

  assign flow_i.ready = state_q == S_IDLE;
  assign div_start    = flow_i.valid && (state_q == S_IDLE) && (src_local || dst_local);

  assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_WR) && can_load && wen_q);
  assign ram_waddr = (state_q == S_CLEAR) ? iss_q[AW-1:0] : slot_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : EW'(ent_q);

  assign res_o.valid        = rv_q;
  assign res_o.outcome      = res_outcome_q;
  assign res_o.direction    = res_dir_q;
  assign res_o.host_addr    = res_host_q;
  assign res_o.bin_second   = res_bin_q;
  assign res_o.bin_start_ms = res_open_q;
  assign res_o.packet_rate  = res_rate_q;
  assign res_o.ema_rate     = res_ema_q;

  always_comb begin
    case (state_q)
      S_D1: begin
        mul_a = keep;
        mul_b = {8'd0, ew_q[47:24]};
      end
      S_D2: begin
        mul_a = aeff;
        mul_b = ent_q.count;
      end
      S_NEWMUL: begin
        mul_a = aeff;
        mul_b = pkts_q;
      end
      default: begin
        mul_a = keep;
        mul_b = {8'd0, ew_q[23:0]};
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    pend_d    = pend_q;
    chk_d     = chk_q;
    slot_d    = slot_q;
    free_d    = free_q;
    free_ok_d = free_ok_q;
    first_d   = first_q;
    nextbin_d = nextbin_q;
    steps_d   = steps_q;
    wen_d     = wen_q;
    out_d     = out_q;
    rv_d      = rv_q;
    host_d    = host_q;
    dir_d     = dir_q;
    pkts_d    = pkts_q;
    ms_d      = ms_q;
    ent_d     = ent_q;
    ew_d      = ew_q;
    lo_d      = lo_q;

    res_outcome_d = res_outcome_q;
    res_dir_d     = res_dir_q;
    res_host_d    = res_host_q;
    res_bin_d     = res_bin_q;
    res_open_d    = res_open_q;
    res_rate_d    = res_rate_q;
    res_ema_d     = res_ema_q;

    if (rv_q && res_o.ready) begin
      rv_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        iss_d = iss_q + 1'b1;
        if (iss_q == (AW + 1)'(TABLE_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (flow_i.valid) begin
          pkts_d = flow_i.packet_count;
          ms_d   = flow_i.start_ms;
          if (src_local) begin
            host_d  = flow_i.src_addr;
            dir_d   = 1'b1;
            state_d = S_DIV;
          end else if (dst_local) begin
            host_d  = flow_i.dst_addr;
            dir_d   = 1'b0;
            state_d = S_DIV;
          end else begin
            out_d   = OUT_IGNORED;
            wen_d   = 1'b0;
            state_d = S_WR;
          end
        end
      end
      S_DIV: begin
        iss_d     = '0;
        pend_d    = 1'b0;
        free_ok_d = 1'b0;
        if (!div_busy) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!iss_done) begin
          iss_d = iss_q + 1'b1;
        end
        pend_d = !iss_done;
        chk_d  = iss_q[AW-1:0];
        if (pend_q) begin
          if (rd.valid && rd.host == host_q && rd.dir == dir_q) begin
            slot_d  = chk_q;
            ent_d   = rd;
            state_d = S_CASE;
          end else if (!rd.valid && !free_ok_q) begin
            free_d    = chk_q;
            free_ok_d = 1'b1;
          end
        end else if (iss_done) begin
          if (free_ok_q) begin
            slot_d  = free_q;
            state_d = S_NEWMUL;
          end else begin
            out_d   = OUT_FULL;
            wen_d   = 1'b0;
            state_d = S_WR;
          end
        end
      end
      S_NEWMUL: begin
        state_d = S_NEW;
      end
      S_NEW: begin
        ent_d.valid   = 1'b1;
        ent_d.dir     = dir_q;
        ent_d.host    = host_q;
        ent_d.bin     = sec;
        ent_d.count   = pkts_q;
        ent_d.rate    = pkts_q;
        ent_d.ema     = prod_q[47:0];
        ent_d.open_ms = ms_q;
        out_d         = OUT_NEW;
        wen_d         = 1'b1;
        state_d       = S_WR;
      end
      S_CASE: begin
        if ({1'b0, sec} <= {1'b0, ent_q.bin}) begin
          ent_d.count = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
          out_d       = OUT_SAME;
          wen_d       = 1'b1;
          state_d     = S_WR;
        end else begin
          ew_d      = ent_q.ema;
          first_d   = 1'b1;
          nextbin_d = {1'b0, sec} <= ({1'b0, ent_q.bin} + 40'd2);
          steps_d   = (diff > 40'(MAX_DECAY_STEPS)) ? SW'(MAX_DECAY_STEPS) : diff[SW-1:0];
          state_d   = S_D0;
        end
      end
      S_D0: begin
        state_d = S_D1;
      end
      S_D1: begin
        lo_d    = prod_q[40:0];
        state_d = S_D2;
      end
      S_D2: begin
        ew_d = dec;
        if (first_q) begin
          state_d = S_AR;
        end else begin
          steps_d = steps_q - 1'b1;
          if (steps_q == SW'(1)) begin
            ent_d.ema     = dec;
            ent_d.bin     = sec;
            ent_d.count   = pkts_q;
            ent_d.rate    = pkts_q;
            ent_d.open_ms = ms_q;
            out_d         = OUT_GAP;
            wen_d         = 1'b1;
            state_d       = S_WR;
          end else begin
            state_d = S_D0;
          end
        end
      end
      S_AR: begin
        ew_d    = esat;
        first_d = 1'b0;
        if (nextbin_q) begin
          out_d         = (rq > esat && (rq - esat) > cfg.thresh) ? OUT_ANOMALY : OUT_NEXT;
          ent_d.ema     = esat;
          ent_d.bin     = ent_q.bin + 39'd1;
          ent_d.count   = pkts_q;
          ent_d.rate    = pkts_q;
          ent_d.open_ms = ms_q;
          wen_d         = 1'b1;
          state_d       = S_WR;
        end else begin
          state_d = S_D0;
        end
      end
      S_WR: begin
        if (can_load) begin
          rv_d          = 1'b1;
          res_outcome_d = out_q;
          res_dir_d     = 1'b0;
          res_host_d    = '0;
          res_bin_d     = '0;
          res_open_d    = '0;
          res_rate_d    = '0;
          res_ema_d     = '0;
          if (out_q != OUT_IGNORED) begin
            res_dir_d  = dir_q;
            res_host_d = host_q;
          end
          if (out_q != OUT_IGNORED && out_q != OUT_FULL) begin
            res_bin_d  = ent_q.bin;
            res_open_d = ent_q.open_ms;
            res_rate_d = ent_q.rate;
            res_ema_d  = ent_q.ema;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      iss_q     <= '0;
      pend_q    <= 1'b0;
      free_ok_q <= 1'b0;
      first_q   <= 1'b0;
      nextbin_q <= 1'b0;
      steps_q   <= '0;
      wen_q     <= 1'b0;
      out_q     <= OUT_IGNORED;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      pend_q    <= pend_d;
      free_ok_q <= free_ok_d;
      first_q   <= first_d;
      nextbin_q <= nextbin_d;
      steps_q   <= steps_d;
      wen_q     <= wen_d;
      out_q     <= out_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q         <= chk_d;
    slot_q        <= slot_d;
    free_q        <= free_d;
    host_q        <= host_d;
    dir_q         <= dir_d;
    pkts_q        <= pkts_d;
    ms_q          <= ms_d;
    ent_q         <= ent_d;
    ew_q          <= ew_d;
    lo_q          <= lo_d;
    prod_q        <= prod_d;
    res_outcome_q <= res_outcome_d;
    res_dir_q     <= res_dir_d;
    res_host_q    <= res_host_d;
    res_bin_q     <= res_bin_d;
    res_open_q    <= res_open_d;
    res_rate_q    <= res_rate_d;
    res_ema_q     <= res_ema_d;
  end
endmodule
